// File: sv/jvm_compare_and_branch_unit_assert.svh
// Assertion macros for the compare and branch unit checker.
`ifndef JVM_COMPARE_AND_BRANCH_UNIT_ASSERT_SVH
`define JVM_COMPARE_AND_BRANCH_UNIT_ASSERT_SVH
// Implication checked every clock outside reset.
`define JCB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define JCB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/jcb_pkg.sv
// ----------------------------------------------------------------------------
// jcb_pkg
// Opcode selectors and constants for the compare and branch unit.
// ----------------------------------------------------------------------------
`default_nettype none
package jcb_pkg;
  localparam logic [31:0] NullRefReset = 32'hFFFF_FC18;
  localparam logic [31:0] LenShort = 32'd3;
  localparam logic [31:0] LenWide = 32'd5;

  typedef enum logic [4:0] {
    F_LCMP = 5'd0, F_FCMPL = 5'd1, F_FCMPG = 5'd2, F_DCMPL = 5'd3, F_DCMPG = 5'd4,
    F_IFEQ = 5'd5, F_IFNE = 5'd6, F_IFLT = 5'd7, F_IFGE = 5'd8, F_IFGT = 5'd9,
    F_IFLE = 5'd10,
    F_ICMPEQ = 5'd11, F_ICMPNE = 5'd12, F_ICMPLT = 5'd13, F_ICMPGE = 5'd14,
    F_ICMPGT = 5'd15, F_ICMPLE = 5'd16,
    F_ACMPEQ = 5'd17, F_ACMPNE = 5'd18, F_IFNULL = 5'd19, F_IFNONNULL = 5'd20,
    F_GOTO = 5'd21, F_GOTO_W = 5'd22, F_JSR = 5'd23, F_JSR_W = 5'd24
  } func_t;
endpackage
`default_nettype wire

// File: sv/jvm_compare_and_branch_unit.sv
// ----------------------------------------------------------------------------
// jvm_compare_and_branch_unit
// One bytecode compare or branch per beat: three-way compares and next pc.
// ----------------------------------------------------------------------------
// channel  direction  signals
// in       sink       in_valid/in_ready, func pc value_deep value_top branch_offset
// out      source     out_valid/out_ready, next_pc taken push_valid push_value
// cfg      sink       cfg_valid/cfg_ready, cfg_data (null_ref)
// One beat per cycle if not stalled; registered result the cycle after acceptance.
// in_ready is high whenever the result register is empty or being drained.
// Synchronous reset empties the result register and sets null_ref to -1000.
// cfg_ready is always high.
`default_nettype none
module jvm_compare_and_branch_unit import jcb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  func,
  input  wire logic [31:0] pc,
  input  wire logic [63:0] value_deep,
  input  wire logic [63:0] value_top,
  input  wire logic signed [31:0] branch_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      next_pc,
  output logic             taken,
  output logic             push_valid,
  output logic [31:0]      push_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  logic [31:0] null_ref;
  logic [31:0] v1l, v2l, off, br_pc, next_pc_next, push_next;
  logic taken_next, pv_next, cond, is_br;
  logic lt_l, eq_l, f_nan, f_eq, f_lt, d_nan, d_eq, d_lt, nan_g;
  logic [31:0] cmp3;

  // IEEE order from sign-magnitude: returns less-than for non-NaN, non-equal values
  function automatic logic flt32(logic [31:0] a, logic [31:0] b);
    if (a[31] != b[31]) return a[31];
    return a[31] ? (a[30:0] > b[30:0]) : (a[30:0] < b[30:0]);
  endfunction
  function automatic logic flt64(logic [63:0] a, logic [63:0] b);
    if (a[63] != b[63]) return a[63];
    return a[63] ? (a[62:0] > b[62:0]) : (a[62:0] < b[62:0]);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    v1l = value_deep[31:0];
    v2l = value_top[31:0];
    off = branch_offset;
    br_pc = pc + off;
    lt_l = $signed(value_deep) < $signed(value_top);
    eq_l = value_deep == value_top;
    f_nan = (v1l[30:23] == 8'hFF && v1l[22:0] != '0) || (v2l[30:23] == 8'hFF && v2l[22:0] != '0);
    f_eq = (v1l == v2l) || (v1l[30:0] == '0 && v2l[30:0] == '0);
    f_lt = flt32(v1l, v2l);
    d_nan = (value_deep[62:52] == 11'h7FF && value_deep[51:0] != '0) ||
            (value_top[62:52] == 11'h7FF && value_top[51:0] != '0);
    d_eq = eq_l || (value_deep[62:0] == '0 && value_top[62:0] == '0);
    d_lt = flt64(value_deep, value_top);
    nan_g = (func == F_FCMPG) || (func == F_DCMPG);
    cmp3 = '0;
    unique case (func)
      F_LCMP: cmp3 = eq_l ? 32'd0 : (lt_l ? '1 : 32'd1);
      F_FCMPL, F_FCMPG:
        cmp3 = f_nan ? (nan_g ? 32'd1 : '1) : (f_eq ? 32'd0 : (f_lt ? '1 : 32'd1));
      F_DCMPL, F_DCMPG:
        cmp3 = d_nan ? (nan_g ? 32'd1 : '1) : (d_eq ? 32'd0 : (d_lt ? '1 : 32'd1));
      default: cmp3 = '0;
    endcase
    cond = 1'b0;
    is_br = 1'b1;
    unique case (func)
      F_IFEQ: cond = v2l == '0;
      F_IFNE: cond = v2l != '0;
      F_IFLT: cond = v2l[31];
      F_IFGE: cond = !v2l[31];
      F_IFGT: cond = !v2l[31] && v2l != '0;
      F_IFLE: cond = v2l[31] || v2l == '0;
      F_ICMPEQ, F_ACMPEQ: cond = v1l == v2l;
      F_ICMPNE, F_ACMPNE: cond = v1l != v2l;
      F_ICMPLT: cond = $signed(v1l) < $signed(v2l);
      F_ICMPGE: cond = $signed(v1l) >= $signed(v2l);
      F_ICMPGT: cond = $signed(v1l) > $signed(v2l);
      F_ICMPLE: cond = $signed(v1l) <= $signed(v2l);
      F_IFNULL: cond = v2l == null_ref;
      F_IFNONNULL: cond = v2l != null_ref;
      default: is_br = 1'b0;
    endcase
    next_pc_next = pc + 32'd1;
    taken_next = 1'b0;
    pv_next = 1'b0;
    push_next = '0;
    if (func <= F_DCMPG) begin
      pv_next = 1'b1;
      push_next = cmp3;
    end else if (is_br) begin
      taken_next = cond;
      next_pc_next = cond ? br_pc : pc + LenShort;
    end else if (func == F_GOTO || func == F_GOTO_W) begin
      taken_next = 1'b1;
      next_pc_next = br_pc;
    end else if (func == F_JSR || func == F_JSR_W) begin
      taken_next = 1'b1;
      pv_next = 1'b1;
      next_pc_next = br_pc;
      push_next = pc + ((func == F_JSR) ? LenShort : LenWide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      null_ref <= NullRefReset;
    end else begin
      if (cfg_valid) null_ref <= cfg_data;
      if (in_ready) out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      next_pc <= next_pc_next;
      taken <= taken_next;
      push_valid <= pv_next;
      push_value <= push_next;
    end
  end
endmodule
`default_nettype wire

// File: sv/jcb_checker.sv
// ----------------------------------------------------------------------------
// jcb_checker
// Port-level checks on the compare and branch unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jvm_compare_and_branch_unit_assert.svh"
module jcb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        push_valid,
  input wire logic [31:0] push_value,
  input wire logic [31:0] next_pc
);
  `JCB_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(next_pc))
  `JCB_ASSERT_NXT(a_beat_out, clk, rst, in_valid && in_ready, out_valid)
  `JCB_ASSERT_IMP(a_push_zero, clk, rst, out_valid && !push_valid, push_value == 32'd0)
  `JCB_ASSERT_IMP(a_ready, clk, rst, !out_valid, in_ready)
endmodule

bind jvm_compare_and_branch_unit jcb_checker u_jcb_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .push_valid(push_valid),
  .push_value(push_value), .next_pc(next_pc)
);
`default_nettype wire
